### hdl/ttpd_pkg.sv
// ----------------------------------------------------------------------------
// Tray tilt PD controller package
// Shared types, register indices, reset values and constants.
// ----------------------------------------------------------------------------
package ttpd_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_KP            = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KD            = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLACE_TARGET  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ZONE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOWER_ZONE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FINISH        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SPEED    = 3'd6;

	localparam logic [9:0]         KP_RST           = 10'd218;
	localparam logic [9:0]         KD_RST           = 10'd77;
	localparam logic signed [15:0] PLACE_TARGET_RST = -16'sd3750;
	localparam logic signed [15:0] SLOW_ZONE_RST    = -16'sd2000;
	localparam logic signed [15:0] SLOWER_ZONE_RST  = -16'sd2800;
	localparam logic signed [15:0] FINISH_RST       = -16'sd3700;
	localparam logic [7:0]         FULL_SPEED_RST   = 8'd100;

	localparam logic [7:0]         SPEED_LIMIT = 8'd200;
	localparam logic [7:0]         SLOW_CAP    = 8'd70;
	localparam logic [7:0]         SLOWER_CAP  = 8'd45;
	localparam logic signed [7:0]  STICK_HI    = 8'sd10;
	localparam logic signed [7:0]  STICK_LO    = -8'sd10;
	localparam logic signed [16:0] ZERO_HI     = 17'sd10;
	localparam logic signed [16:0] ZERO_LO     = -17'sd10;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [9:0]  kp_q8;
		logic [9:0]  kd_q8;
		logic [15:0] place_target;
		logic [15:0] slow_zone_start;
		logic [15:0] slower_zone_start;
		logic [15:0] finish_position;
		logic [7:0]  full_speed;
	} cfg_t;

	typedef struct packed {
		logic [15:0] raw_position;
		logic        limit_pressed;
		logic        main_up;
		logic        main_left;
		logic        main_right;
		logic        main_down;
		logic        partner_a;
		logic        partner_b;
		logic [7:0]  partner_stick;
	} in_t;

	typedef enum logic [2:0] {
		SRC_NONE,
		SRC_DRIVE,
		SRC_SPEED_NEG,
		SRC_SPEED_POS,
		SRC_STICK_NEG
	} vel_src_t;

	typedef struct packed {
		vel_src_t    src;
		logic [17:0] err;
		logic [18:0] diff;
		logic [7:0]  cap;
		logic [7:0]  speed;
		logic [7:0]  stick;
		logic        reset_req;
		logic        light_req;
		logic        tare;
	} job_t;

endpackage

### hdl/ttpd_front.sv
// ----------------------------------------------------------------------------
// Tray tilt front end
// Applies commands, tare and end-of-place rules, keeps the controller state
// and classifies each request into a job for the drive back end.
// ----------------------------------------------------------------------------
module ttpd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ttpd_pkg::in_t    item,
	input  ttpd_pkg::cfg_t   cfg,
	output logic             job_valid,
	input  logic             job_ready,
	output ttpd_pkg::job_t   job
);

	logic signed [16:0] target_q;
	logic signed [17:0] prev_err_q;
	logic               placing_q;
	logic               latched_q;
	logic signed [15:0] offset_q;

	logic signed [16:0] target_d;
	logic               placing_d;
	logic               latched_d;
	logic signed [15:0] offset_d;

	logic signed [16:0] pos;
	logic signed [16:0] pos2;
	logic signed [16:0] target1;
	logic signed [17:0] err;
	logic signed [18:0] diff;
	logic signed [7:0]  stick;
	logic signed [16:0] place_t;
	logic signed [16:0] slow_z;
	logic signed [16:0] slower_z;
	logic signed [16:0] finish_p;
	logic [7:0]         speed;
	logic [7:0]         cap;
	logic               light;
	logic               rst_req;
	logic               tare;
	ttpd_pkg::vel_src_t src;
	logic               accept;

	assign in_ready  = job_ready;
	assign job_valid = in_valid;
	assign accept    = in_valid && job_ready;

	always_comb begin
		stick    = $signed(item.partner_stick);
		place_t  = 17'($signed(cfg.place_target));
		slow_z   = 17'($signed(cfg.slow_zone_start));
		slower_z = 17'($signed(cfg.slower_zone_start));
		finish_p = 17'($signed(cfg.finish_position));
		speed    = (cfg.full_speed > ttpd_pkg::SPEED_LIMIT) ? ttpd_pkg::SPEED_LIMIT
			: cfg.full_speed;
		pos      = 17'($signed(item.raw_position)) - 17'(offset_q);

		light     = 1'b0;
		rst_req   = 1'b0;
		tare      = 1'b0;
		placing_d = placing_q;
		latched_d = latched_q;
		target1   = target_q;
		offset_d  = offset_q;

		if (item.main_right) begin
			light     = 1'b1;
			placing_d = 1'b1;
			target1   = place_t;
			latched_d = 1'b1;
		end else if (item.main_down || item.partner_b) begin
			placing_d = 1'b0;
			rst_req   = 1'b1;
			latched_d = 1'b1;
		end else if (item.partner_a) begin
			light     = 1'b1;
			placing_d = 1'b1;
			target1   = place_t;
		end else if (!latched_q) begin
			placing_d = 1'b0;
			target1   = pos;
		end

		if (placing_d && pos >= slow_z) begin
			cap = speed;
		end else if (placing_d && pos < slow_z && pos > slower_z) begin
			cap = ttpd_pkg::SLOW_CAP;
		end else if (placing_d && pos < slower_z && pos >= place_t) begin
			cap = ttpd_pkg::SLOWER_CAP;
		end else begin
			cap = speed;
		end

		err  = 18'(target1) - 18'(pos);
		diff = 19'(err) - 19'(prev_err_q);

		target_d = target1;
		pos2     = pos;
		src      = ttpd_pkg::SRC_DRIVE;

		if (!item.limit_pressed) begin
			if (item.main_up) begin
				src      = ttpd_pkg::SRC_SPEED_NEG;
				target_d = pos;
			end else if (item.main_left) begin
				src      = ttpd_pkg::SRC_SPEED_POS;
				target_d = pos;
			end else if (stick > ttpd_pkg::STICK_HI || stick < ttpd_pkg::STICK_LO) begin
				src      = ttpd_pkg::SRC_STICK_NEG;
				target_d = pos;
			end else if (pos < ttpd_pkg::ZERO_HI && pos > ttpd_pkg::ZERO_LO
					&& target1 == 17'sd0) begin
				src     = ttpd_pkg::SRC_NONE;
				rst_req = 1'b1;
			end else begin
				src = ttpd_pkg::SRC_DRIVE;
			end
		end else begin
			if (!placing_d) begin
				offset_d = $signed(item.raw_position);
				pos2     = 17'sd0;
				target_d = 17'sd0;
				tare     = 1'b1;
			end
			if (item.main_left) begin
				src = ttpd_pkg::SRC_DRIVE;
			end else if (item.main_up) begin
				src      = ttpd_pkg::SRC_SPEED_NEG;
				target_d = pos2;
			end else if (stick <= ttpd_pkg::STICK_LO) begin
				src = ttpd_pkg::SRC_DRIVE;
			end else if (stick >= ttpd_pkg::STICK_HI) begin
				src      = ttpd_pkg::SRC_STICK_NEG;
				target_d = pos2;
			end else begin
				src = ttpd_pkg::SRC_DRIVE;
			end
		end

		if (pos2 <= finish_p) begin
			placing_d = 1'b0;
			target_d  = pos2;
			latched_d = 1'b0;
		end else if (pos2 == 17'sd0) begin
			latched_d = 1'b0;
		end

		job.src       = src;
		job.err       = err;
		job.diff      = diff;
		job.cap       = cap;
		job.speed     = speed;
		job.stick     = item.partner_stick;
		job.reset_req = rst_req;
		job.light_req = light;
		job.tare      = tare;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			prev_err_q <= '0;
			placing_q  <= 1'b0;
			latched_q  <= 1'b0;
			offset_q   <= '0;
		end else if (accept) begin
			target_q   <= target_d;
			prev_err_q <= err;
			placing_q  <= placing_d;
			latched_q  <= latched_d;
			offset_q   <= offset_d;
		end
	end

endmodule

### hdl/ttpd_queue.sv
// ----------------------------------------------------------------------------
// Tray tilt job queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module ttpd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  ttpd_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output ttpd_pkg::job_t pop_job
);

	localparam int PTR_W = $clog2(ttpd_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(ttpd_pkg::QUEUE_DEPTH + 1);

	ttpd_pkg::job_t   mem_q [ttpd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(ttpd_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(ttpd_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(ttpd_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ttpd_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue count did not follow a lone push");
`endif

endmodule

### hdl/ttpd_back.sv
// ----------------------------------------------------------------------------
// Tray tilt drive back end
// Forms the Q8 PD drive, clamps it to the cap and selects the velocity
// command. Two stages: products, then sum, clamp and output register.
// ----------------------------------------------------------------------------
module ttpd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ttpd_pkg::cfg_t    cfg,
	input  logic              job_valid,
	output logic              job_ready,
	input  ttpd_pkg::job_t    job,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [8:0] velocity,
	output logic              velocity_valid,
	output logic              reset_request,
	output logic              light_request,
	output logic              tare_done
);

	logic                 valid_s1;
	ttpd_pkg::vel_src_t   src_s1;
	logic signed [28:0]   p_kp_s1;
	logic signed [29:0]   p_kd_s1;
	logic [7:0]           cap_s1;
	logic [7:0]           speed_s1;
	logic [7:0]           stick_s1;
	logic                 rst_s1;
	logic                 light_s1;
	logic                 tare_s1;

	logic                 valid_s2;
	logic signed [8:0]    vel_s2;
	logic                 vel_valid_s2;
	logic                 rst_s2;
	logic                 light_s2;
	logic                 tare_s2;

	logic                 adv_s2;
	logic                 adv_s1;
	logic signed [30:0]   q;
	logic signed [30:0]   lim;
	logic signed [30:0]   q_adj;
	logic signed [30:0]   q_shift;
	logic signed [8:0]    drive;
	logic signed [8:0]    vel;

	assign adv_s2    = !valid_s2 || out_ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign job_ready = adv_s1;

	always_ff @(posedge clk) begin
		if (adv_s1 && job_valid) begin
			src_s1   <= job.src;
			p_kp_s1  <= 29'($signed({1'b0, cfg.kp_q8})) * 29'($signed(job.err));
			p_kd_s1  <= 30'($signed({1'b0, cfg.kd_q8})) * 30'($signed(job.diff));
			cap_s1   <= job.cap;
			speed_s1 <= job.speed;
			stick_s1 <= job.stick;
			rst_s1   <= job.reset_req;
			light_s1 <= job.light_req;
			tare_s1  <= job.tare;
		end
	end

	always_comb begin
		q       = 31'(p_kp_s1) + 31'(p_kd_s1);
		lim     = 31'($signed({1'b0, cap_s1, 8'h00}));
		q_adj   = q + (q[30] ? 31'sd255 : 31'sd0);
		q_shift = q_adj >>> 8;
		if (q > lim) begin
			drive = $signed({1'b0, cap_s1});
		end else if (q < -lim) begin
			drive = 9'sd0 - $signed({1'b0, cap_s1});
		end else begin
			drive = q_shift[8:0];
		end
		unique case (src_s1)
			ttpd_pkg::SRC_DRIVE:     vel = drive;
			ttpd_pkg::SRC_SPEED_NEG: vel = 9'sd0 - $signed({1'b0, speed_s1});
			ttpd_pkg::SRC_SPEED_POS: vel = $signed({1'b0, speed_s1});
			ttpd_pkg::SRC_STICK_NEG: vel = 9'sd0 - $signed({stick_s1[7], stick_s1});
			default:                 vel = 9'sd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			vel_s2       <= vel;
			vel_valid_s2 <= (src_s1 != ttpd_pkg::SRC_NONE);
			rst_s2       <= rst_s1;
			light_s2     <= light_s1;
			tare_s2      <= tare_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= job_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign out_valid      = valid_s2;
	assign velocity       = vel_s2;
	assign velocity_valid = vel_valid_s2;
	assign reset_request  = rst_s2;
	assign light_request  = light_s2;
	assign tare_done      = tare_s2;

`ifndef SYNTH
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !vel_valid_s2) |-> (vel_s2 == 9'sd0 && rst_s2))
		else $error("silent tick without zero velocity and reset request");
	a_tare_drives: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && tare_s2) |-> vel_valid_s2)
		else $error("tare tick issued no velocity");
`endif

endmodule

### hdl/tray_tilt_pd_controller.sv
// ----------------------------------------------------------------------------
// Tray tilt PD controller
// Top level: configuration registers, front end, job queue and drive back end.
// ----------------------------------------------------------------------------
// One request on the input channel is one control tick: encoder count, limit
// switch, buttons and partner stick. Each tick gives exactly one result on the
// output channel: a velocity with its valid flag and the reset, light and
// tare pulses.
// The front end updates the controller state in the cycle a request is
// taken, so a request may be taken in every cycle. The result passes through
// the queue entry, the product stage and the output register, and while the
// receiver does not stall the sustained rate is one request per cycle, set by
// the state update in the front end.
// When the receiver stalls, the output register and the back-end stage hold
// and the two-entry queue fills; input ready falls only once the queue is
// full, and it rises again as soon as a result is taken.
// Configuration writes are accepted in every cycle and should be made only
// while no request is in flight. Reset restores the register defaults and
// clears the target, error, place flags and tare offset.
// ----------------------------------------------------------------------------
module tray_tilt_pd_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ttpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [15:0]               raw_position,
	input  logic                             limit_pressed,
	input  logic                             main_up,
	input  logic                             main_left,
	input  logic                             main_right,
	input  logic                             main_down,
	input  logic                             partner_a,
	input  logic                             partner_b,
	input  logic signed [7:0]                partner_stick,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [8:0]                velocity,
	output logic                             velocity_valid,
	output logic                             reset_request,
	output logic                             light_request,
	output logic                             tare_done
);

	ttpd_pkg::cfg_t cfg_q;
	ttpd_pkg::in_t  item;
	ttpd_pkg::job_t front_job;
	ttpd_pkg::job_t back_job;
	logic           front_valid;
	logic           front_ready;
	logic           back_valid;
	logic           back_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_q8             <= ttpd_pkg::KP_RST;
			cfg_q.kd_q8             <= ttpd_pkg::KD_RST;
			cfg_q.place_target      <= ttpd_pkg::PLACE_TARGET_RST;
			cfg_q.slow_zone_start   <= ttpd_pkg::SLOW_ZONE_RST;
			cfg_q.slower_zone_start <= ttpd_pkg::SLOWER_ZONE_RST;
			cfg_q.finish_position   <= ttpd_pkg::FINISH_RST;
			cfg_q.full_speed        <= ttpd_pkg::FULL_SPEED_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ttpd_pkg::CFG_KP:           cfg_q.kp_q8             <= cfg_data[9:0];
				ttpd_pkg::CFG_KD:           cfg_q.kd_q8             <= cfg_data[9:0];
				ttpd_pkg::CFG_PLACE_TARGET: cfg_q.place_target      <= cfg_data;
				ttpd_pkg::CFG_SLOW_ZONE:    cfg_q.slow_zone_start   <= cfg_data;
				ttpd_pkg::CFG_SLOWER_ZONE:  cfg_q.slower_zone_start <= cfg_data;
				ttpd_pkg::CFG_FINISH:       cfg_q.finish_position   <= cfg_data;
				ttpd_pkg::CFG_FULL_SPEED:   cfg_q.full_speed        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		item.raw_position  = raw_position;
		item.limit_pressed = limit_pressed;
		item.main_up       = main_up;
		item.main_left     = main_left;
		item.main_right    = main_right;
		item.main_down     = main_down;
		item.partner_a     = partner_a;
		item.partner_b     = partner_b;
		item.partner_stick = partner_stick;
	end

	ttpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.item      (item),
		.cfg       (cfg_q),
		.job_valid (front_valid),
		.job_ready (front_ready),
		.job       (front_job)
	);

	ttpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_job   (front_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_job    (back_job)
	);

	ttpd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.job_valid      (back_valid),
		.job_ready      (back_ready),
		.job            (back_job),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.velocity       (velocity),
		.velocity_valid (velocity_valid),
		.reset_request  (reset_request),
		.light_request  (light_request),
		.tare_done      (tare_done)
	);

endmodule
